// ===== rtl/bscff_pkg.sv =====
// Shared types, codes and sizes for the bit map allocator.
`default_nettype none

package bscff_pkg;

    // Map size in bytes, one cell per byte
    localparam int MAX_BYTES = 128;

    // Cell position counter wide enough to count past the last cell
    localparam int POS_W = $clog2(MAX_BYTES + 1);
    // Common width for comparing position with byte index and active size
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    localparam int BIT_IDX_W  = 10;
    localparam int BYTE_IDX_W = BIT_IDX_W - 3;

    // Request codes
    localparam logic [2:0] FUNC_SET       = 3'd0;
    localparam logic [2:0] FUNC_CLEAR     = 3'd1;
    localparam logic [2:0] FUNC_TEST      = 3'd2;
    localparam logic [2:0] FUNC_SET_ALL   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_ALL = 3'd4;
    localparam logic [2:0] FUNC_FIND      = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Request traveling down the row of cells, collecting its result
    typedef struct packed {
        logic [2:0]            func;
        logic [BYTE_IDX_W-1:0] byte_idx;
        logic [2:0]            bit_off;
        logic [POS_W-1:0]      pos;
        logic                  hit;
        logic                  was_set;
        logic                  found;
        logic [BIT_IDX_W-1:0]  found_idx;
    } packet_t;

endpackage

`default_nettype wire

// ===== rtl/bscff_cell.sv =====
// One byte of the bit map and the logic that applies a passing request to it.
`default_nettype none

module bscff_cell
    import bscff_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire packet_t in_pkt,
    input  wire logic [7:0] active_bytes,
    output logic         out_valid,
    output packet_t      out_pkt
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       out_valid_reg;
    packet_t    out_pkt_reg;
    packet_t    pkt_next;

    logic       in_use;
    logic       match;
    logic [7:0] mask;
    logic [2:0] clear_pos;
    logic       has_clear;

    // Locate this cell against the request
    assign in_use = CMP_W'(in_pkt.pos) < CMP_W'(active_bytes);
    assign match  = in_use && (CMP_W'(in_pkt.pos) == CMP_W'(in_pkt.byte_idx));
    assign mask   = 8'b1 << in_pkt.bit_off;

    // Lowest clear bit of this byte
    always_comb
    begin
        clear_pos = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (!byte_reg[b])
            begin
                clear_pos = 3'(b);
            end
        end
        has_clear = (byte_reg != 8'hFF);
    end

    // Apply the request to the byte and update the traveling result
    always_comb
    begin
        byte_next    = byte_reg;
        pkt_next     = in_pkt;
        pkt_next.pos = in_pkt.pos + POS_W'(1);
        if (in_valid)
        begin
            case (in_pkt.func)
                FUNC_SET:
                begin
                    if (match)
                    begin
                        byte_next    = byte_reg | mask;
                        pkt_next.hit = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    if (match)
                    begin
                        byte_next    = byte_reg & ~mask;
                        pkt_next.hit = 1'b1;
                    end
                end
                FUNC_TEST:
                begin
                    if (match)
                    begin
                        pkt_next.hit     = 1'b1;
                        pkt_next.was_set = |(byte_reg & mask);
                    end
                end
                FUNC_SET_ALL:
                begin
                    if (in_use)
                    begin
                        byte_next = 8'hFF;
                    end
                end
                FUNC_CLEAR_ALL:
                begin
                    if (in_use)
                    begin
                        byte_next = 8'h00;
                    end
                end
                FUNC_FIND:
                begin
                    if (in_use && !in_pkt.found && has_clear)
                    begin
                        byte_next          = byte_reg | (8'b1 << clear_pos);
                        pkt_next.found     = 1'b1;
                        pkt_next.found_idx = BIT_IDX_W'({in_pkt.pos, clear_pos});
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Byte storage and hand-off stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_reg      <= byte_next;
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pkt_reg <= pkt_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pkt   = out_pkt_reg;

endmodule

`default_nettype wire

// ===== rtl/bitmap_set_clear_find_free.sv =====
// Top level of the bit map allocator: request entry, row of byte cells, result.
//
// Usage:
//   Request channel: drive func and bit_index with start high; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with status, bit_was_set and
//   found_index; the receiver cannot stall, the result must be taken then.
//   Config channel: cfg_valid/cfg_ready write active_bytes (reset 128);
//   cfg_ready is low while busy or start is high, so no write meets a request.
// Flow:
//   Each request walks the row of MAX_BYTES byte cells, one cell per cycle,
//   through the register of each cell before done rises, for every request,
//   and busy falls in the cycle after done.
//   One request is in flight at a time; a new one is taken only once busy is low.
// Reset:
//   Asynchronous active-low rst_n clears all map bits, drops any request in
//   flight and sets active_bytes to 128.
`default_nettype none

module bitmap_set_clear_find_free
    import bscff_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           func,
    input  wire logic [BIT_IDX_W-1:0] bit_index,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [7:0]           cfg_data,
    output logic                      done,
    output logic [1:0]                status,
    output logic                      bit_was_set,
    output logic [BIT_IDX_W-1:0]      found_index
);

    logic       busy_reg;
    logic       busy_next;
    logic [7:0] active_bytes_reg;
    logic       accept;

    logic       link_valid [MAX_BYTES+1];
    packet_t    link_pkt   [MAX_BYTES+1];
    packet_t    last_pkt;

    assign accept    = start && !busy_reg;
    assign cfg_ready = !busy_reg && !start;

    // Fresh request enters the first cell
    always_comb
    begin
        link_valid[0]        = accept;
        link_pkt[0]          = '0;
        link_pkt[0].func     = func;
        link_pkt[0].byte_idx = bit_index[BIT_IDX_W-1:3];
        link_pkt[0].bit_off  = bit_index[2:0];
    end

    // Row of byte cells
    for (genvar i = 0; i < MAX_BYTES; i++)
    begin : g_cell
        bscff_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (link_valid[i]),
            .in_pkt       (link_pkt[i]),
            .active_bytes (active_bytes_reg),
            .out_valid    (link_valid[i+1]),
            .out_pkt      (link_pkt[i+1])
        );
    end

    assign last_pkt = link_pkt[MAX_BYTES];

    // Busy from acceptance until the result leaves the row
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (link_valid[MAX_BYTES])
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            active_bytes_reg <= 8'd128;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_valid && cfg_ready)
            begin
                active_bytes_reg <= cfg_data;
            end
        end
    end

    // Result decode at the end of the row
    always_comb
    begin
        case (last_pkt.func)
            FUNC_SET, FUNC_CLEAR, FUNC_TEST:
                status = last_pkt.hit ? STATUS_OK : STATUS_RANGE;
            FUNC_FIND:
                status = last_pkt.found ? STATUS_OK : STATUS_FULL;
            default:
                status = STATUS_OK;
        endcase
    end

    assign busy        = busy_reg;
    assign done        = link_valid[MAX_BYTES];
    assign bit_was_set = last_pkt.was_set;
    assign found_index = last_pkt.found_idx;

    // A result only leaves while a request is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("result without request in flight");

    // Busy drops right after the result
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg)
        else $error("busy held after result");

    // An accepted request raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised on accept");

    // Claimed index is only reported on a successful find
    a_found_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_pkt.func != FUNC_FIND) |-> (found_index == '0))
        else $error("found index on a non-find request");

endmodule

`default_nettype wire

// ===== dv/bitmap_alloc_checker.sv =====
// Checker for the bit map allocator: tracks the map, predicts each result, compares.
`timescale 1ns / 1ps

module bitmap_alloc_checker
    import bscff_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [2:0]           func,
    input  wire logic [BIT_IDX_W-1:0] bit_index,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 done,
    input  wire logic [1:0]           status,
    input  wire logic                 bit_was_set,
    input  wire logic [BIT_IDX_W-1:0] found_index,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        logic [1:0]           status;
        logic                 was_set;
        logic [BIT_IDX_W-1:0] found_idx;
    } alloc_reply_t;

    // Shadow copy of the map and the active size
    logic [7:0]   map_bytes [MAX_BYTES];
    logic [7:0]   active_bytes;
    alloc_reply_t owed_replies [$];
    int           mismatches = 0;
    int           owed_n = 0;

    assign fail_count  = mismatches;
    assign outstanding = owed_n;

    // Apply one request to the shadow map and return the reply it must produce
    function automatic alloc_reply_t apply_request(input logic [2:0] fn,
                                                   input logic [BIT_IDX_W-1:0] idx);
        alloc_reply_t r;
        int           used;
        int           byte_no;
        int           i;
        int           b;
        logic [7:0]   mask;
        r       = '0;
        used    = (active_bytes > MAX_BYTES) ? MAX_BYTES : active_bytes;
        byte_no = idx >> 3;
        mask    = 8'h01 << idx[2:0];
        case (fn)
            FUNC_SET, FUNC_CLEAR, FUNC_TEST:
            begin
                if (byte_no >= used)
                    r.status = STATUS_RANGE;
                else if (fn == FUNC_SET)
                    map_bytes[byte_no] = map_bytes[byte_no] | mask;
                else if (fn == FUNC_CLEAR)
                    map_bytes[byte_no] = map_bytes[byte_no] & ~mask;
                else
                    r.was_set = |(map_bytes[byte_no] & mask);
            end
            FUNC_SET_ALL:
            begin
                for (i = 0; i < used; i++)
                    map_bytes[i] = 8'hFF;
            end
            FUNC_CLEAR_ALL:
            begin
                for (i = 0; i < used; i++)
                    map_bytes[i] = 8'h00;
            end
            FUNC_FIND:
            begin
                // lowest clear bit in the bytes in use; full if none
                r.status = STATUS_FULL;
                for (i = 0; i < used && r.status == STATUS_FULL; i++)
                begin
                    if (map_bytes[i] != 8'hFF)
                    begin
                        b = 0;
                        while (map_bytes[i][b])
                            b++;
                        map_bytes[i][b] = 1'b1;
                        r.found_idx     = BIT_IDX_W'(i * 8 + b);
                        r.status        = STATUS_OK;
                    end
                end
            end
            default:
            begin
                // spare codes: no effect, all-zero reply
            end
        endcase
        return r;
    endfunction

    // Watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        alloc_reply_t want;
        int           k;
        if (!rst_n)
        begin
            for (k = 0; k < MAX_BYTES; k++)
                map_bytes[k] = 8'h00;
            active_bytes = 8'd128;
            owed_replies.delete();
            owed_n <= 0;
        end
        else
        begin
            // result first, so it meets the oldest expectation
            if (done)
            begin
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d was_set %0d found %0d",
                             $time, status, bit_was_set, found_index);
                    mismatches++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (bit_was_set !== want.was_set)
                    begin
                        $display("%0t: bit_was_set expected %0d actual %0d",
                                 $time, want.was_set, bit_was_set);
                        mismatches++;
                    end
                    if (found_index !== want.found_idx)
                    begin
                        $display("%0t: found_index expected %0d actual %0d",
                                 $time, want.found_idx, found_index);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                active_bytes = cfg_data;
            if (start && !busy)
                owed_replies.push_back(apply_request(func, bit_index));
            owed_n <= owed_replies.size();
        end
    end

endmodule

// ===== dv/tb_bitmap_set_clear_find_free.sv =====
// Testbench top for the bit map allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_bitmap_set_clear_find_free
    import bscff_pkg::*;
();

    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         RANDOM_ITEMS = 450;
    localparam int         PHASES       = 6;
    // codes the block leaves unused
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           func;
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [7:0]           cfg_data;
    logic                 done;
    logic [1:0]           status;
    logic                 bit_was_set;
    logic [BIT_IDX_W-1:0] found_index;
    int                   fail_count;
    int                   outstanding;
    int                   cycle_count = 0;
    bit                   steady;      // request side never idles while set
    logic [7:0]           active_now;  // last active size written

    bitmap_set_clear_find_free u_dut (.*);

    bitmap_alloc_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item until taken; idles at random unless steady
    task automatic issue(input logic [2:0] fn, input logic [BIT_IDX_W-1:0] idx);
        bit go;
        forever
        begin
            go = steady || ($urandom_range(99) >= 10);
            start <= go;
            if (go)
            begin
                func      <= fn;
                bit_index <= idx;
            end
            else
            begin
                func      <= 3'($urandom);
                bit_index <= BIT_IDX_W'($urandom);
            end
            @(posedge clk);
            if (go && !busy)
                break;
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Write active_bytes once the block has drained
    task automatic write_active(input logic [7:0] value);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        active_now = value;
    endtask

    // Mostly in-range bits, some anywhere in the field
    function automatic logic [BIT_IDX_W-1:0] pick_index();
        int used;
        used = (active_now > MAX_BYTES) ? MAX_BYTES : active_now;
        if (used == 0 || $urandom_range(99) < 15)
            return BIT_IDX_W'($urandom_range(1023));
        return BIT_IDX_W'($urandom_range(8 * used - 1));
    endfunction

    // Weighted toward finds and single-bit requests
    function automatic logic [2:0] pick_func();
        int r;
        r = $urandom_range(99);
        if (r < 22)
            return FUNC_SET;
        if (r < 40)
            return FUNC_CLEAR;
        if (r < 60)
            return FUNC_TEST;
        if (r < 88)
            return FUNC_FIND;
        if (r < 92)
            return FUNC_SET_ALL;
        if (r < 96)
            return FUNC_CLEAR_ALL;
        return $urandom_range(1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    endfunction

    initial
    begin
        logic [7:0] sizes [PHASES];
        int         p;
        int         n;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_SET;
        bit_index  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 8'd0;
        steady     = 1'b0;
        active_now = 8'd128;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: full map at reset size
        issue(FUNC_TEST, 10'd0);
        issue(FUNC_SET, 10'd0);
        issue(FUNC_TEST, 10'd0);
        issue(FUNC_SET, 10'd1023);
        issue(FUNC_TEST, 10'd1023);
        issue(FUNC_CLEAR, 10'd0);
        issue(FUNC_TEST, 10'd0);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_FIND, 10'd1023);
        issue(FUNC_SET_ALL, 10'd0);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_CLEAR, 10'd517);
        issue(FUNC_FIND, 10'd1023);
        issue(FUNC_CLEAR_ALL, 10'd0);
        issue(FUNC_SPARE_6, 10'd1023);
        issue(FUNC_SPARE_7, 10'd0);
        // two bytes in use: out of range, then full
        write_active(8'd2);
        issue(FUNC_SET, 10'd16);
        issue(FUNC_TEST, 10'd15);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_SET_ALL, 10'd0);
        issue(FUNC_FIND, 10'd0);
        // nothing in use
        write_active(8'd0);
        issue(FUNC_SET, 10'd0);
        issue(FUNC_FIND, 10'd0);
        issue(FUNC_CLEAR_ALL, 10'd0);
        // size beyond the map; old bytes reappear
        write_active(8'd255);
        issue(FUNC_TEST, 10'd1023);
        issue(FUNC_TEST, 10'd15);

        // Random phases, one active size each; phase 2 runs with no idling
        sizes[0] = 8'd3;
        sizes[1] = 8'd128;
        sizes[2] = 8'd1;
        sizes[3] = 8'd255;
        sizes[4] = 8'($urandom_range(16, 1));
        sizes[5] = 8'($urandom_range(128, 1));
        for (p = 0; p < PHASES; p++)
        begin
            write_active(sizes[p]);
            steady = (p == 2);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
                issue(pick_func(), pick_index());
        end
        steady = 1'b0;

        // Drain, then watch for stray results
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (MAX_BYTES + 8) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bscff_pkg.sv
rtl/bscff_cell.sv
rtl/bitmap_set_clear_find_free.sv
dv/bitmap_alloc_checker.sv
dv/tb_bitmap_set_clear_find_free.sv
